### rtl/rsas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsas_pkg: shared types and constants for the rotated sorted array search
// Request and result payloads, request type codes and back-end status.
// ----------------------------------------------------------------------------
package rsas_pkg;

  // Request type codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // Widest value the datapath supports; inputs are sign-extended to this first
  localparam int EXT_W = 64;

  // Entries in the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Input request as it arrives on the port
  typedef struct packed {
    logic               req_type;
    logic [9:0]         load_index;
    logic signed [31:0] load_value;
    logic signed [31:0] search_target;
    logic [10:0]        element_count;
  } in_item_t;

  // Result of one search
  typedef struct packed {
    logic       found;
    logic [9:0] found_index;
  } out_item_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic busy;
    logic result_pending;
  } stat_t;

endpackage
`default_nettype wire

### rtl/rsas_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsas_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rsas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/rsas_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsas_front: request intake and command queue
// Classifies requests, drops out-of-range loads, normalizes values and
// counts, and buffers commands for the back end.
// ----------------------------------------------------------------------------
module rsas_front #(
  parameter int  MAX_ELEMENTS = 1024,
  parameter int  VALUE_WIDTH  = 32,
  parameter type cmd_t        = logic
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rsas_pkg::in_item_t in_data,
  output logic                    q_valid,
  input  wire logic               q_ready,
  output cmd_t                    q_data
);

  import rsas_pkg::*;

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int QP_W  = $clog2(QUEUE_DEPTH);
  localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

  cmd_t              queue_r [QUEUE_DEPTH];
  logic [QP_W-1:0]   wptr_r, wptr_nxt;
  logic [QP_W-1:0]   rptr_r, rptr_nxt;
  logic [QC_W-1:0]   fill_r, fill_nxt;

  logic                    is_search;
  logic signed [31:0]      sel_val;
  logic signed [EXT_W-1:0] val_ext;
  logic                    keep;
  logic                    push;
  logic                    pop;
  cmd_t                    cmd;

  // Classify and normalize the incoming request
  always_comb begin
    is_search     = (in_data.req_type == REQ_SEARCH);
    sel_val       = is_search ? in_data.search_target : in_data.load_value;
    val_ext       = EXT_W'(sel_val);
    cmd.is_search = is_search;
    cmd.index     = IDX_W'(in_data.load_index);
    cmd.value     = val_ext[VALUE_WIDTH-1:0];
    cmd.count     = (32'(in_data.element_count) > MAX_ELEMENTS) ?
                    CNT_W'(MAX_ELEMENTS) : CNT_W'(in_data.element_count);
    // drop loads beyond the store
    keep          = is_search || (32'(in_data.load_index) < MAX_ELEMENTS);
  end

  assign in_ready = (fill_r != QC_W'(QUEUE_DEPTH));
  assign q_valid  = (fill_r != '0);
  assign q_data   = queue_r[rptr_r];
  assign push     = in_valid && in_ready && keep;
  assign pop      = q_valid && q_ready;

  // Advance queue pointers and fill level
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    fill_nxt = fill_r;
    if (push) begin
      wptr_nxt = (32'(wptr_r) == QUEUE_DEPTH - 1) ? '0 : wptr_r + QP_W'(1);
    end
    if (pop) begin
      rptr_nxt = (32'(rptr_r) == QUEUE_DEPTH - 1) ? '0 : rptr_r + QP_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + QC_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Store the command payload
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wptr_r] <= cmd;
    end
  end

endmodule
`default_nettype wire

### rtl/rsas_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsas_back: search sequencer
// Executes loads into the element RAM and runs the rotated binary search,
// one command at a time, then holds the result in an output register.
// ----------------------------------------------------------------------------
module rsas_back #(
  parameter int  MAX_ELEMENTS = 1024,
  parameter int  VALUE_WIDTH  = 32,
  parameter type cmd_t        = logic
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_valid,
  output logic                                 q_ready,
  input  wire cmd_t                            q_data,
  output logic                                 ram_we,
  output logic [$clog2(MAX_ELEMENTS)-1:0]      ram_waddr,
  output logic [VALUE_WIDTH-1:0]               ram_wdata,
  output logic                                 ram_re,
  output logic [$clog2(MAX_ELEMENTS)-1:0]      ram_raddr,
  input  wire logic [VALUE_WIDTH-1:0]          ram_rdata,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output rsas_pkg::out_item_t                  out_data,
  output rsas_pkg::stat_t                      stat
);

  import rsas_pkg::*;

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int PTR_W = CNT_W + 1;

  typedef logic signed [PTR_W-1:0]       ptr_t;
  typedef logic signed [VALUE_WIDTH-1:0] val_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ISSUE = 7'b0000010,
    S_MIDV  = 7'b0000100,
    S_LOV   = 7'b0001000,
    S_M1V   = 7'b0010000,
    S_HIV   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  ptr_t       lo_r, lo_nxt;
  ptr_t       hi_r, hi_nxt;
  logic [IDX_W-1:0] mid_r, mid_nxt;
  val_t       tgt_r, tgt_nxt;
  val_t       mid_val_r, mid_val_nxt;
  val_t       m1_val_r, m1_val_nxt;
  logic       plain_r, plain_nxt;
  logic       res_found_r, res_found_nxt;
  logic [IDX_W-1:0] res_idx_r, res_idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;

  val_t rd;
  ptr_t mid_ext;
  ptr_t mid_p1;
  ptr_t mid_m1;
  ptr_t mid_new;

  assign rd      = $signed(ram_rdata);
  assign mid_ext = ptr_t'($signed({1'b0, mid_r}));
  assign mid_p1  = ptr_t'(mid_ext + ptr_t'(1));
  assign mid_m1  = ptr_t'(mid_ext - ptr_t'(1));
  assign mid_new = ptr_t'(lo_r + ((hi_r - lo_r) >>> 1));

  assign q_ready   = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign stat.busy           = (state_r != S_IDLE);
  assign stat.result_pending = out_valid_r;

  // Sequence loads and search probes
  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    tgt_nxt       = tgt_r;
    mid_val_nxt   = mid_val_r;
    m1_val_nxt    = m1_val_r;
    plain_nxt     = plain_r;
    res_found_nxt = res_found_r;
    res_idx_nxt   = res_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = q_data.index;
    ram_wdata     = q_data.value;
    ram_re        = 1'b0;
    ram_raddr     = mid_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_data.is_search) begin
            tgt_nxt   = q_data.value;
            lo_nxt    = '0;
            hi_nxt    = ptr_t'($signed({1'b0, q_data.count}) - 1);
            plain_nxt = 1'b0;
            state_nxt = S_ISSUE;
          end else begin
            ram_we = 1'b1;
          end
        end
      end
      S_ISSUE: begin
        // range empty: not found
        if (lo_r > hi_r) begin
          res_found_nxt = 1'b0;
          res_idx_nxt   = '0;
          state_nxt     = S_DONE;
        end else begin
          mid_nxt   = mid_new[IDX_W-1:0];
          ram_re    = 1'b1;
          ram_raddr = mid_new[IDX_W-1:0];
          state_nxt = S_MIDV;
        end
      end
      S_MIDV: begin
        mid_val_nxt = rd;
        if (rd == tgt_r) begin
          res_found_nxt = 1'b1;
          res_idx_nxt   = mid_r;
          state_nxt     = S_DONE;
        end else if (plain_r) begin
          if (rd <= tgt_r) begin
            lo_nxt = mid_p1;
          end else begin
            hi_nxt = mid_m1;
          end
          state_nxt = S_ISSUE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = lo_r[IDX_W-1:0];
          state_nxt = S_LOV;
        end
      end
      S_LOV: begin
        // left half sorted
        if (rd <= mid_val_r) begin
          if (rd <= tgt_r && tgt_r <= mid_val_r) begin
            plain_nxt = 1'b1;
            hi_nxt    = mid_ext;
          end else begin
            lo_nxt = mid_p1;
          end
          state_nxt = S_ISSUE;
        end else if (mid_p1 <= hi_r) begin
          ram_re    = 1'b1;
          ram_raddr = mid_p1[IDX_W-1:0];
          state_nxt = S_M1V;
        end else begin
          res_found_nxt = 1'b0;
          res_idx_nxt   = '0;
          state_nxt     = S_DONE;
        end
      end
      S_M1V: begin
        m1_val_nxt = rd;
        ram_re     = 1'b1;
        ram_raddr  = hi_r[IDX_W-1:0];
        state_nxt  = S_HIV;
      end
      S_HIV: begin
        // right half sorted
        if (m1_val_r <= tgt_r && tgt_r <= rd) begin
          plain_nxt = 1'b1;
          lo_nxt    = mid_p1;
        end else begin
          hi_nxt = mid_m1;
        end
        state_nxt = S_ISSUE;
      end
      S_DONE: begin
        // hand off once the output slot is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.found       = res_found_r;
          out_data_nxt.found_index = 10'(res_idx_r);
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold search context and result payload
  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    tgt_r       <= tgt_nxt;
    mid_val_r   <= mid_val_nxt;
    m1_val_r    <= m1_val_nxt;
    plain_r     <= plain_nxt;
    res_found_r <= res_found_nxt;
    res_idx_r   <= res_idx_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule
`default_nettype wire

### rtl/rotated_sorted_array_search.sv
`timescale 1ns / 1ps
`default_nettype none
// Order: a load is registered in the command queue and then written to the RAM
//   by the sequencer; a search issues its probes through the single RAM read
//   port, its probe states running from ISSUE through MIDV, LOV, M1V and HIV.
// Throughput: sequencer serves one request at a time; when idle, 1 load per cycle.
// Reset: rst_n clears queue and sequencer control; the element RAM is not
//   cleared and holds undefined data until loaded.
// ----------------------------------------------------------------------------
// rotated_sorted_array_search: rotated binary search over a loaded array
// Front end queues requests; back end loads elements and runs the search.
// ----------------------------------------------------------------------------
module rotated_sorted_array_search #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int VALUE_WIDTH  = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire rsas_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output rsas_pkg::out_item_t      out_data
);

  import rsas_pkg::*;

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  typedef struct packed {
    logic                   is_search;
    logic [IDX_W-1:0]       index;
    logic [VALUE_WIDTH-1:0] value;
    logic [CNT_W-1:0]       count;
  } cmd_t;

  logic             q_valid;
  logic             q_ready;
  cmd_t             q_data;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;
  stat_t            stat;

  // Intake and command queue
  rsas_front #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .VALUE_WIDTH (VALUE_WIDTH),
    .cmd_t       (cmd_t)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data)
  );

  // Load and search sequencer
  rsas_back #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .VALUE_WIDTH (VALUE_WIDTH),
    .cmd_t       (cmd_t)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .stat     (stat)
  );

  // Element store
  rsas_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(MAX_ELEMENTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Loads and probes never share a cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !ram_re)
    else $error("RAM write and read in the same cycle");

  // Commands leave the queue only when the sequencer is idle
  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_ready) |-> !stat.busy)
    else $error("command popped while a search is running");

  // Probes are issued only during a search
  a_read_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> stat.busy)
    else $error("RAM read outside a search");

  // A new result follows a search in progress
  a_result_from_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(stat.busy))
    else $error("result raised without a search");

endmodule
`default_nettype wire
